// ----- sv/bbo_pkg.sv -----
// Shared constants and types for the bounding box overlay unit.
// No dependencies; compile first.
package bbo_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int BORDER_BITS    = 8;
    localparam int COLOR_BITS     = 24;
    localparam int MODE_BITS      = 2;
    localparam int CROSS_REACH    = 4;

    localparam logic [7:0] WHITE_BYTE = 8'hFF;

    // draw_mode codes; code 3 acts as box with cross
    localparam logic [MODE_BITS-1:0] MODE_FILL  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BOX   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CROSS = 2'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOX_LEFT   = 3'd0,
        REG_BOX_TOP    = 3'd1,
        REG_BOX_WIDTH  = 3'd2,
        REG_BOX_HEIGHT = 3'd3,
        REG_BORDER     = 3'd4,
        REG_COLOR      = 3'd5,
        REG_MODE       = 3'd6
    } bbo_reg_idx_t;

endpackage

// ----- sv/bbo_if.sv -----
// Valid/ready channel interfaces: pixel words in, pixel words out, register writes.
// Depends on bbo_pkg.
interface bbo_pix_if #(parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COORD_BITS:0]   frame_width;
    logic [COORD_BITS:0]   frame_height;
    logic [7:0]            in_ch0;
    logic [7:0]            in_ch1;
    logic [7:0]            in_ch2;

    modport source (output valid, pixel_x, pixel_y, frame_width, frame_height,
                    in_ch0, in_ch1, in_ch2, input ready);
    modport sink   (input valid, pixel_x, pixel_y, frame_width, frame_height,
                    in_ch0, in_ch1, in_ch2, output ready);
endinterface

interface bbo_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic       was_marked;

    modport source (output valid, out_ch0, out_ch1, out_ch2, was_marked, input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_ch2, was_marked, output ready);
endinterface

interface bbo_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bbo_pkg::CFG_IDX_BITS-1:0]   index;
    logic [bbo_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/bbo_cfg_regs.sv -----
// Configuration register file, written through the register write channel.
// Depends on bbo_pkg and bbo_cfg_if.
module bbo_cfg_regs #(
    parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bbo_cfg_if.sink                              cfg,
    output logic signed [COORD_BITS:0]           box_left,
    output logic signed [COORD_BITS:0]           box_top,
    output logic [COORD_BITS-1:0]                box_width,
    output logic [COORD_BITS-1:0]                box_height,
    output logic [bbo_pkg::BORDER_BITS-1:0]      border_thickness,
    output logic [bbo_pkg::COLOR_BITS-1:0]       mark_color,
    output logic [bbo_pkg::MODE_BITS-1:0]        draw_mode
);
    import bbo_pkg::*;

    logic signed [COORD_BITS:0] box_left_reg;
    logic signed [COORD_BITS:0] box_top_reg;
    logic [COORD_BITS-1:0]      box_width_reg;
    logic [COORD_BITS-1:0]      box_height_reg;
    logic [BORDER_BITS-1:0]     border_reg;
    logic [COLOR_BITS-1:0]      color_reg;
    logic [MODE_BITS-1:0]       mode_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
            border_reg     <= BORDER_BITS'(1);
            color_reg      <= '0;
            mode_reg       <= MODE_BOX;
        end
        else if (cfg.valid)
        begin
            case (bbo_reg_idx_t'(cfg.index))
                REG_BOX_LEFT:   box_left_reg   <= cfg.data[COORD_BITS:0];
                REG_BOX_TOP:    box_top_reg    <= cfg.data[COORD_BITS:0];
                REG_BOX_WIDTH:  box_width_reg  <= cfg.data[COORD_BITS-1:0];
                REG_BOX_HEIGHT: box_height_reg <= cfg.data[COORD_BITS-1:0];
                REG_BORDER:     border_reg     <= cfg.data[BORDER_BITS-1:0];
                REG_COLOR:      color_reg      <= cfg.data[COLOR_BITS-1:0];
                REG_MODE:       mode_reg       <= cfg.data[MODE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign box_left         = box_left_reg;
    assign box_top          = box_top_reg;
    assign box_width        = box_width_reg;
    assign box_height       = box_height_reg;
    assign border_thickness = border_reg;
    assign mark_color       = color_reg;
    assign draw_mode        = mode_reg;

endmodule

// ----- sv/bbo_mark_logic.sv -----
// Per-pixel region, border and center-cross decision and color select.
// Depends on bbo_pkg.
module bbo_mark_logic #(
    parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS:0]      box_left,
    input  logic signed [COORD_BITS:0]      box_top,
    input  logic [COORD_BITS-1:0]           box_width,
    input  logic [COORD_BITS-1:0]           box_height,
    input  logic [bbo_pkg::BORDER_BITS-1:0] border_thickness,
    input  logic [bbo_pkg::COLOR_BITS-1:0]  mark_color,
    input  logic [bbo_pkg::MODE_BITS-1:0]   draw_mode,
    input  logic [COORD_BITS-1:0]           pixel_x,
    input  logic [COORD_BITS-1:0]           pixel_y,
    input  logic [COORD_BITS:0]             frame_width,
    input  logic [COORD_BITS:0]             frame_height,
    input  logic [7:0]                      in_ch0,
    input  logic [7:0]                      in_ch1,
    input  logic [7:0]                      in_ch2,
    output logic [7:0]                      out_ch0,
    output logic [7:0]                      out_ch1,
    output logic [7:0]                      out_ch2,
    output logic                            was_marked
);
    import bbo_pkg::*;

    // signed working width: covers origin + size and origin - thickness
    localparam int W = COORD_BITS + 3;
    localparam logic signed [W-1:0] ONE_W       = W'(1);
    localparam logic signed [W-1:0] REACH_W     = W'(CROSS_REACH);
    localparam logic signed [W-1:0] NEG_REACH_W = -REACH_W;

    logic signed [W-1:0] bl_w, bt_w, left_w, top_w, bw_w, bh_w, t_w;
    logic signed [W-1:0] x_w, y_w, fw_w, fh_w;
    logic signed [W-1:0] right_w, bottom_w, right_c, bottom_c;
    logic signed [W-1:0] cx_w, cy_w, dx_w, dy_w;
    logic in_region, on_border, on_cross, paint_mark, paint_white;

    assign bl_w   = {{2{box_left[COORD_BITS]}}, box_left};
    assign bt_w   = {{2{box_top[COORD_BITS]}}, box_top};
    assign left_w = box_left[COORD_BITS] ? '0 : bl_w;
    assign top_w  = box_top[COORD_BITS]  ? '0 : bt_w;
    assign bw_w   = {3'b000, box_width};
    assign bh_w   = {3'b000, box_height};
    assign t_w    = {{(W-BORDER_BITS){1'b0}}, border_thickness};
    assign x_w    = {3'b000, pixel_x};
    assign y_w    = {3'b000, pixel_y};
    assign fw_w   = {2'b00, frame_width};
    assign fh_w   = {2'b00, frame_height};

    // region end, clamped to the last column/row (exclusive)
    assign right_w  = left_w + bw_w;
    assign bottom_w = top_w + bh_w;
    assign right_c  = (right_w >= fw_w)  ? fw_w - ONE_W : right_w;
    assign bottom_c = (bottom_w >= fh_w) ? fh_w - ONE_W : bottom_w;

    assign in_region = (x_w >= left_w) && (x_w < right_c)
                    && (y_w >= top_w) && (y_w < bottom_c);

    // border measured from the unclamped box edges
    assign on_border = (draw_mode == MODE_FILL)
                    || (x_w < bl_w + t_w) || (x_w >= bl_w + bw_w - t_w)
                    || (y_w < bt_w + t_w) || (y_w >= bt_w + bh_w - t_w);

    assign cx_w = bl_w + {4'b0000, box_width[COORD_BITS-1:1]};
    assign cy_w = bt_w + {4'b0000, box_height[COORD_BITS-1:1]};
    assign dx_w = x_w - cx_w;
    assign dy_w = y_w - cy_w;

    assign on_cross = (draw_mode >= MODE_CROSS)
                   && (((dx_w == '0) && (dy_w > NEG_REACH_W) && (dy_w < REACH_W))
                    || ((dy_w == '0) && (dx_w > NEG_REACH_W) && (dx_w < REACH_W)));

    assign paint_mark  = in_region && on_border;
    assign paint_white = in_region && !on_border && on_cross;

    always_comb
    begin
        if (paint_mark)
        begin
            out_ch0 = mark_color[7:0];
            out_ch1 = mark_color[15:8];
            out_ch2 = mark_color[23:16];
        end
        else if (paint_white)
        begin
            out_ch0 = WHITE_BYTE;
            out_ch1 = WHITE_BYTE;
            out_ch2 = WHITE_BYTE;
        end
        else
        begin
            out_ch0 = in_ch0;
            out_ch1 = in_ch1;
            out_ch2 = in_ch2;
        end
    end

    assign was_marked = paint_mark || paint_white;

endmodule

// ----- sv/bounding_box_overlay_unit.sv -----
// Bounding box overlay unit: top level with input and result registers.
// Depends on bbo_pkg, bbo_if, bbo_cfg_regs, bbo_mark_logic.
//
// Usage:
//   pixels  - sink of pixel words: coordinates, frame size and three color bytes.
//   results - source of result words: the three color bytes after overlay and
//             was_marked. Exactly one result word per pixel word, in order.
//   cfg     - register writes (index, data); always ready. Write only while
//             no pixel word is in flight.
// Words pass the input register, then are offered from the result register.
// Throughput: one word per clock. The input register and result register form
//   a two-stage pipeline; the mark decision is a single combinational pass
//   between them, so a new word is taken every cycle as long as results drain.
// Stall: when results is not taken, the result register holds its word and the
//   input register takes one more word only if it is empty; then pixels.ready
//   drops until the result register frees up. No word is dropped or repeated.
// Reset (rst_n low, asynchronous): both pipeline stages empty, configuration
//   registers take border_thickness 1, draw_mode box, everything else 0.
module bounding_box_overlay_unit #(
    parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bbo_pix_if.sink    pixels,
    bbo_res_if.source  results,
    bbo_cfg_if.sink    cfg
);
    import bbo_pkg::*;

    // configuration
    logic signed [COORD_BITS:0] box_left, box_top;
    logic [COORD_BITS-1:0]      box_width, box_height;
    logic [BORDER_BITS-1:0]     border_thickness;
    logic [COLOR_BITS-1:0]      mark_color;
    logic [MODE_BITS-1:0]       draw_mode;

    // input stage
    logic                  s1_valid_reg, s1_valid_next;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [COORD_BITS:0]   fw_reg, fh_reg;
    logic [7:0]            c0_reg, c1_reg, c2_reg;

    // result stage
    logic       s2_valid_reg, s2_valid_next;
    logic [7:0] o0_reg, o1_reg, o2_reg;
    logic       marked_reg;

    // combinational result of the input stage
    logic [7:0] o0_comb, o1_comb, o2_comb;
    logic       marked_comb;

    logic pix_acc;
    logic s1_adv;

    bbo_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .box_left         (box_left),
        .box_top          (box_top),
        .box_width        (box_width),
        .box_height       (box_height),
        .border_thickness (border_thickness),
        .mark_color       (mark_color),
        .draw_mode        (draw_mode)
    );

    // handshake: input stage moves on when the result stage is empty or drains
    assign s1_adv       = !s2_valid_reg || results.ready;
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign pix_acc      = pixels.valid && pixels.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pix_acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        s2_valid_next = s1_adv ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            x_reg  <= pixels.pixel_x;
            y_reg  <= pixels.pixel_y;
            fw_reg <= pixels.frame_width;
            fh_reg <= pixels.frame_height;
            c0_reg <= pixels.in_ch0;
            c1_reg <= pixels.in_ch1;
            c2_reg <= pixels.in_ch2;
        end
        if (s1_adv && s1_valid_reg)
        begin
            o0_reg     <= o0_comb;
            o1_reg     <= o1_comb;
            o2_reg     <= o2_comb;
            marked_reg <= marked_comb;
        end
    end

    bbo_mark_logic #(.COORD_BITS(COORD_BITS)) u_mark (
        .box_left         (box_left),
        .box_top          (box_top),
        .box_width        (box_width),
        .box_height       (box_height),
        .border_thickness (border_thickness),
        .mark_color       (mark_color),
        .draw_mode        (draw_mode),
        .pixel_x          (x_reg),
        .pixel_y          (y_reg),
        .frame_width      (fw_reg),
        .frame_height     (fh_reg),
        .in_ch0           (c0_reg),
        .in_ch1           (c1_reg),
        .in_ch2           (c2_reg),
        .out_ch0          (o0_comb),
        .out_ch1          (o1_comb),
        .out_ch2          (o2_comb),
        .was_marked       (marked_comb)
    );

    assign results.valid      = s2_valid_reg;
    assign results.out_ch0    = o0_reg;
    assign results.out_ch1    = o1_reg;
    assign results.out_ch2    = o2_reg;
    assign results.was_marked = marked_reg;

    // a stalled result word must hold the input stage back
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !results.ready |-> !s1_adv)
        else $error("input stage advanced over a stalled result");

    // never accept over a held, full input stage
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |-> (!s1_valid_reg || s1_adv))
        else $error("pixel word accepted over a held word");

    // a word moving on from the input stage shows up as a result word
    a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_valid_reg |=> s2_valid_reg)
        else $error("pixel word lost between stages");

endmodule
